// ----- hw/rtl/trz_pkg.sv -----
// Shared types and constants of the triangle rasterizer with depth buffer.
`timescale 1ns / 1ps
`default_nettype none

package trz_pkg;

	localparam int SCREEN_W_DEF = 512;
	localparam int SCREEN_H_DEF = 512;

	localparam int STORE_DEPTH = 262144;
	localparam int ADDR_W      = 18;
	localparam int COORD_W     = 12;
	localparam int IDX_W       = 24;
	localparam int WW          = 36;
	localparam int AW          = 36;
	localparam int NW          = 60;
	localparam int ZW          = 24;
	localparam int CNT_W       = 19;
	localparam int COLOR_W     = 32;
	localparam int CMDQ_DEPTH  = 2;

	localparam logic [1:0] OP_DRAW  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] K_DRAW  = 2'd0;
	localparam logic [1:0] K_NONE  = 2'd1;
	localparam logic [1:0] K_CLEAR = 2'd2;
	localparam logic [1:0] K_READ  = 2'd3;

	localparam logic [1:0] CFG_DEPTH_ONLY  = 2'd0;
	localparam logic [1:0] CFG_CLEAR_COLOR = 2'd1;
	localparam logic [1:0] CFG_CLEAR_DEPTH = 2'd2;

	typedef struct packed {
		logic [1:0]               kind;
		logic [ADDR_W-1:0]        addr;
		logic [COLOR_W-1:0]       color;
		logic [COORD_W-1:0]       x0;
		logic [COORD_W-1:0]       xn;
		logic [COORD_W-1:0]       y0;
		logic [COORD_W-1:0]       yn;
		logic [IDX_W-1:0]         idx0;
		logic [2:0][WW-1:0]       w;
		logic [2:0][WW-1:0]       dwx;
		logic [2:0][WW-1:0]       dwy;
		logic [NW-1:0]            n0;
		logic [NW-1:0]            nx;
		logic [NW-1:0]            ny;
		logic [AW-1:0]            den;
	} cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/triangle_raster_zbuffer.sv -----
// Top level: configuration registers, setup front end, command queue, pixel back end.
//
//  channel   direction  handshake                transfer when
//  input     in         push / full              push && !full
//  result    out        empty / pop              pop && !empty
//  config    in         cfg_we                   cfg_we
//
// Draw: setup runs on the front multiplier, then the back end visits each box pixel;
// a covered pixel also runs the 25-step divider and a store read and write. Clear
// writes all 262144 store entries, one entry per cycle. Read fetches one entry.
// Reset clears control only; the stores hold garbage until a clear. The front
// stalls (full) during setup and while the queue is full; the back stalls when a
// result is still waiting to be popped.
`timescale 1ns / 1ps
`default_nettype none

module triangle_raster_zbuffer import trz_pkg::*; #(
	parameter int SCREEN_W = SCREEN_W_DEF,
	parameter int SCREEN_H = SCREEN_H_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] ax,
	input  wire logic signed [15:0] ay,
	input  wire logic signed [23:0] az,
	input  wire logic signed [15:0] bx,
	input  wire logic signed [15:0] by_coord,
	input  wire logic signed [23:0] bz,
	input  wire logic signed [15:0] cx,
	input  wire logic signed [15:0] cy,
	input  wire logic signed [23:0] cz,
	input  wire logic [8:0]         light_level,
	input  wire logic [17:0]        read_address,
	output logic                    empty,
	input  wire logic               pop,
	output logic [18:0]             pixels_written,
	output logic [31:0]             read_color,
	output logic signed [23:0]      read_depth,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	logic               depth_only_q;
	logic [COLOR_W-1:0] clear_color_q;
	logic [ZW-1:0]      clear_depth_q;

	logic q_push, q_full, q_pop, q_empty;
	cmd_t q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_only_q  <= 1'b0;
			clear_color_q <= 32'h2121_2100;
			clear_depth_q <= 24'h7F_FFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEPTH_ONLY:  depth_only_q  <= cfg_data[0];
				CFG_CLEAR_COLOR: clear_color_q <= cfg_data;
				CFG_CLEAR_DEPTH: clear_depth_q <= cfg_data[ZW-1:0];
				default: ;
			endcase
		end
	end

	trz_front #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.ax           (ax),
		.ay           (ay),
		.az           (az),
		.bx           (bx),
		.by_coord     (by_coord),
		.bz           (bz),
		.cx           (cx),
		.cy           (cy),
		.cz           (cz),
		.light_level  (light_level),
		.read_address (read_address),
		.q_push       (q_push),
		.q_data       (q_wdata),
		.q_full       (q_full)
	);

	trz_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	trz_back #(
		.SCREEN_W (SCREEN_W)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_empty      (q_empty),
		.cmd            (q_rdata),
		.cmd_pop        (q_pop),
		.depth_only     (depth_only_q),
		.clear_color    (clear_color_q),
		.clear_depth    (clear_depth_q),
		.pop            (pop),
		.empty          (empty),
		.pixels_written (pixels_written),
		.read_color     (read_color),
		.read_depth     (read_depth)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/trz_front.sv -----
// Front end: accepts operations and runs triangle setup on one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module trz_front import trz_pkg::*; #(
	parameter int SCREEN_W = SCREEN_W_DEF,
	parameter int SCREEN_H = SCREEN_H_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] ax,
	input  wire logic signed [15:0] ay,
	input  wire logic signed [23:0] az,
	input  wire logic signed [15:0] bx,
	input  wire logic signed [15:0] by_coord,
	input  wire logic signed [23:0] bz,
	input  wire logic signed [15:0] cx,
	input  wire logic signed [15:0] cy,
	input  wire logic signed [23:0] cz,
	input  wire logic [8:0]         light_level,
	input  wire logic [17:0]        read_address,
	output logic                    q_push,
	output cmd_t                    q_data,
	input  wire logic               q_full
);

	localparam logic [1:0] F_IDLE  = 2'd0;
	localparam logic [1:0] F_SETUP = 2'd1;
	localparam logic [1:0] F_PUSH  = 2'd2;
	localparam logic [4:0] ST_LAST = 5'd19;
	localparam int         SW      = 44;

	logic [1:0]         state_q;
	logic [4:0]         st_q;
	logic [4:0]         tag_q;
	logic               tv_q;
	logic [1:0]         op_q;
	logic signed [15:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic signed [23:0] az_q, bz_q, cz_q;
	logic [8:0]         light_q;
	logic [17:0]        addr_q;

	logic signed [SW-1:0] prod_q;
	logic signed [AW-1:0] area_q;
	logic signed [WW-1:0] w_q [3];
	logic signed [SW-1:0] sy_q, sx_q;
	logic signed [NW-1:0] n0_q;

	logic signed [16:0] ex1, ey1, ex2, ey2, ex3, ey3;
	logic signed [15:0] lox, hix, loy, hiy;
	logic [COORD_W-1:0] x0, xn_raw, xn, y0, yn_raw, yn;
	logic               box_ok;
	logic signed [18:0] px0, py0;
	logic signed [24:0] ma;
	logic signed [18:0] mb;
	logic [8:0]         lsat;
	logic [16:0]        gp;
	logic [7:0]         grey;
	logic [1:0]         kind;

	function automatic logic signed [15:0] min3(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [15:0] c);
		logic signed [15:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [15:0] max3(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [15:0] c);
		logic signed [15:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic signed [18:0] whi(input logic signed [WW-1:0] w);
		return 19'($signed(w[WW-1:18]));
	endfunction

	function automatic logic signed [18:0] wlo(input logic signed [WW-1:0] w);
		return $signed({1'b0, w[17:0]});
	endfunction

	assign ex1 = 17'(cx_q) - 17'(bx_q);
	assign ey1 = 17'(cy_q) - 17'(by_q);
	assign ex2 = 17'(ax_q) - 17'(cx_q);
	assign ey2 = 17'(ay_q) - 17'(cy_q);
	assign ex3 = 17'(bx_q) - 17'(ax_q);
	assign ey3 = 17'(by_q) - 17'(ay_q);

	// clip the bounding box to the screen
	assign lox = min3(ax_q, bx_q, cx_q);
	assign hix = max3(ax_q, bx_q, cx_q);
	assign loy = min3(ay_q, by_q, cy_q);
	assign hiy = max3(ay_q, by_q, cy_q);
	assign x0 = lox[15] ? '0 : COORD_W'(lox[14:4]);
	assign y0 = loy[15] ? '0 : COORD_W'(loy[14:4]);
	assign xn_raw = COORD_W'(hix[14:4]);
	assign yn_raw = COORD_W'(hiy[14:4]);
	assign xn = (xn_raw > COORD_W'(SCREEN_W - 1)) ? COORD_W'(SCREEN_W - 1) : xn_raw;
	assign yn = (yn_raw > COORD_W'(SCREEN_H - 1)) ? COORD_W'(SCREEN_H - 1) : yn_raw;
	assign box_ok = !hix[15] && !hiy[15] && (x0 <= xn) && (y0 <= yn);
	assign px0 = $signed({3'b000, x0, 4'b0000});
	assign py0 = $signed({3'b000, y0, 4'b0000});

	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			5'd0:  begin ma = 25'(cx_q) - 25'(ax_q); mb = 19'(ey3); end
			5'd1:  begin ma = 25'(cy_q) - 25'(ay_q); mb = 19'(ex3); end
			5'd2:  begin ma = 25'(px0) - 25'(bx_q); mb = 19'(ey1); end
			5'd3:  begin ma = 25'(py0) - 25'(by_q); mb = 19'(ex1); end
			5'd4:  begin ma = 25'(px0) - 25'(cx_q); mb = 19'(ey2); end
			5'd5:  begin ma = 25'(py0) - 25'(cy_q); mb = 19'(ex2); end
			5'd6:  begin ma = 25'(px0) - 25'(ax_q); mb = 19'(ey3); end
			5'd7:  begin ma = 25'(py0) - 25'(ay_q); mb = 19'(ex3); end
			5'd8:  begin ma = 25'(az_q); mb = 19'(ey1); end
			5'd9:  begin ma = 25'(bz_q); mb = 19'(ey2); end
			5'd10: begin ma = 25'(cz_q); mb = 19'(ey3); end
			5'd11: begin ma = 25'(az_q); mb = 19'(ex1); end
			5'd12: begin ma = 25'(bz_q); mb = 19'(ex2); end
			5'd13: begin ma = 25'(cz_q); mb = 19'(ex3); end
			5'd14: begin ma = 25'(az_q); mb = whi(w_q[0]); end
			5'd15: begin ma = 25'(az_q); mb = wlo(w_q[0]); end
			5'd16: begin ma = 25'(bz_q); mb = whi(w_q[1]); end
			5'd17: begin ma = 25'(bz_q); mb = wlo(w_q[1]); end
			5'd18: begin ma = 25'(cz_q); mb = whi(w_q[2]); end
			5'd19: begin ma = 25'(cz_q); mb = wlo(w_q[2]); end
			default: ;
		endcase
	end

	assign lsat = (light_q > 9'd256) ? 9'd256 : light_q;
	assign gp   = 17'(lsat) * 17'(200);
	assign grey = gp[15:8];

	always_comb begin
		case (op_q)
			OP_DRAW:  kind = (area_q[AW-1] && box_ok) ? K_DRAW : K_NONE;
			OP_CLEAR: kind = K_CLEAR;
			OP_READ:  kind = K_READ;
			default:  kind = K_NONE;
		endcase
	end

	always_comb begin
		q_data.kind   = kind;
		q_data.addr   = addr_q;
		q_data.color  = {grey, grey, grey, 8'h00};
		q_data.x0     = x0;
		q_data.xn     = xn;
		q_data.y0     = y0;
		q_data.yn     = yn;
		q_data.idx0   = IDX_W'(y0) * IDX_W'(SCREEN_W) + IDX_W'(x0);
		q_data.w[0]   = w_q[0];
		q_data.w[1]   = w_q[1];
		q_data.w[2]   = w_q[2];
		q_data.dwx[0] = WW'(ey1) <<< 4;
		q_data.dwx[1] = WW'(ey2) <<< 4;
		q_data.dwx[2] = WW'(ey3) <<< 4;
		q_data.dwy[0] = -(WW'(ex1) <<< 4);
		q_data.dwy[1] = -(WW'(ex2) <<< 4);
		q_data.dwy[2] = -(WW'(ex3) <<< 4);
		q_data.n0     = n0_q;
		q_data.nx     = -(NW'(sy_q) <<< 4);
		q_data.ny     = NW'(sx_q) <<< 4;
		q_data.den    = -area_q;
	end

	assign full   = (state_q != F_IDLE);
	assign q_push = (state_q == F_PUSH) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			st_q    <= '0;
			tv_q    <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					st_q <= '0;
					tv_q <= 1'b0;
					if (push) begin
						state_q <= (opcode == OP_DRAW) ? F_SETUP : F_PUSH;
					end
				end
				F_SETUP: begin
					tv_q <= (st_q <= ST_LAST);
					if (st_q <= ST_LAST) begin
						st_q <= st_q + 5'd1;
					end
					if (tv_q && tag_q == ST_LAST) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// operand capture and setup accumulators
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			op_q    <= opcode;
			ax_q    <= ax;
			ay_q    <= ay;
			az_q    <= az;
			bx_q    <= bx;
			by_q    <= by_coord;
			bz_q    <= bz;
			cx_q    <= cx;
			cy_q    <= cy;
			cz_q    <= cz;
			light_q <= light_level;
			addr_q  <= read_address;
		end
		if (state_q == F_SETUP) begin
			prod_q <= ma * mb;
			tag_q  <= st_q;
			if (tv_q) begin
				case (tag_q)
					5'd0:  area_q <= AW'(prod_q);
					5'd1:  area_q <= area_q - AW'(prod_q);
					5'd2:  w_q[0] <= WW'(prod_q);
					5'd3:  w_q[0] <= w_q[0] - WW'(prod_q);
					5'd4:  w_q[1] <= WW'(prod_q);
					5'd5:  w_q[1] <= w_q[1] - WW'(prod_q);
					5'd6:  w_q[2] <= WW'(prod_q);
					5'd7:  w_q[2] <= w_q[2] - WW'(prod_q);
					5'd8:  sy_q <= prod_q;
					5'd9:  sy_q <= sy_q + prod_q;
					5'd10: sy_q <= sy_q + prod_q;
					5'd11: sx_q <= prod_q;
					5'd12: sx_q <= sx_q + prod_q;
					5'd13: sx_q <= sx_q + prod_q;
					5'd14: n0_q <= -(NW'(prod_q) <<< 18);
					5'd15: n0_q <= n0_q - NW'(prod_q);
					5'd16: n0_q <= n0_q - (NW'(prod_q) <<< 18);
					5'd17: n0_q <= n0_q - NW'(prod_q);
					5'd18: n0_q <= n0_q - (NW'(prod_q) <<< 18);
					5'd19: n0_q <= n0_q - NW'(prod_q);
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/trz_cmdq.sv -----
// Short command queue between the setup front end and the pixel back end.
`timescale 1ns / 1ps
`default_nettype none

module trz_cmdq import trz_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	output logic      full,
	input  wire logic pop,
	output cmd_t      rdata,
	output logic      empty
);

	localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;

	cmd_t          mem_q [CMDQ_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (PW + 1)'(CMDQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/trz_div.sv -----
// Per-pixel depth divider: restoring division, one quotient bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module trz_div import trz_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [NW-1:0] num,
	input  wire logic [AW-1:0]      den,
	output logic                    done,
	output logic signed [ZW-1:0]    z
);

	localparam int QB = ZW + 1;
	localparam int DW = 64;
	localparam int KW = $clog2(QB);

	logic          busy_q, done_q;
	logic [KW-1:0] k_q;
	logic [DW-1:0] rem_q, ds_q;
	logic [QB-1:0] q_q;

	assign done = done_q;
	// quotient carries a bias of 2^ZW that keeps the dividend non-negative
	assign z = $signed(q_q[ZW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == KW'(QB - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// floor((2*num + den) / (2*den)): num/den rounded to nearest with ties up, plus bias
			rem_q <= (DW'(num) <<< 1) + DW'(den) + (DW'(den) << QB);
			ds_q  <= DW'(den) << QB;
			q_q   <= '0;
		end else if (busy_q) begin
			if (rem_q >= ds_q) begin
				rem_q <= rem_q - ds_q;
				q_q   <= {q_q[QB-2:0], 1'b1};
			end else begin
				q_q <= {q_q[QB-2:0], 1'b0};
			end
			ds_q <= ds_q >> 1;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/trz_back.sv -----
// Back end: walks the pixel box, owns the color and depth stores, forms results.
`timescale 1ns / 1ps
`default_nettype none

module trz_back import trz_pkg::*; #(
	parameter int SCREEN_W = SCREEN_W_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_empty,
	input  wire cmd_t                cmd,
	output logic                     cmd_pop,
	input  wire logic                depth_only,
	input  wire logic [COLOR_W-1:0]  clear_color,
	input  wire logic [ZW-1:0]       clear_depth,
	input  wire logic                pop,
	output logic                     empty,
	output logic [CNT_W-1:0]         pixels_written,
	output logic [COLOR_W-1:0]       read_color,
	output logic signed [ZW-1:0]     read_depth
);

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_PIX  = 3'd1;
	localparam logic [2:0] B_DIV  = 3'd2;
	localparam logic [2:0] B_CLR  = 3'd3;
	localparam logic [2:0] B_RD   = 3'd4;
	localparam logic [2:0] B_RDW  = 3'd5;
	localparam logic [2:0] B_DONE = 3'd6;

	logic [2:0]          state_q;
	cmd_t                c_q;
	logic [COORD_W-1:0]  x_q, y_q;
	logic [2:0][WW-1:0]  cw_q, rw_q;
	logic [NW-1:0]       cn_q, rn_q;
	logic [IDX_W-1:0]    ci_q, ri_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [COLOR_W-1:0]  pc_q;
	logic [ZW-1:0]       pd_q;
	logic                res_v_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic [COLOR_W-1:0]  res_color_q;
	logic [ZW-1:0]       res_depth_q;

	logic [ZW-1:0]       dmem [STORE_DEPTH];
	logic [COLOR_W-1:0]  cmem [STORE_DEPTH];
	logic [ZW-1:0]       rdd_q;
	logic [COLOR_W-1:0]  rdc_q;

	logic                in_tri, last_x, last_y, adv, z_lt, hit;
	logic                res_load;
	logic                div_start, div_done;
	logic signed [ZW-1:0] div_z;
	logic                we_d, we_c;
	logic [ADDR_W-1:0]   wa, ra;
	logic [ZW-1:0]       wd;
	logic [COLOR_W-1:0]  wc;
	logic [2:0][WW-1:0]  rw_next;
	logic [NW-1:0]       rn_next;
	logic [IDX_W-1:0]    ri_next;

	trz_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ($signed(cn_q)),
		.den    (c_q.den),
		.done   (div_done),
		.z      (div_z)
	);

	assign in_tri = cw_q[0][WW-1] && cw_q[1][WW-1] && cw_q[2][WW-1] &&
		(ci_q < IDX_W'(STORE_DEPTH));
	assign last_x = (x_q == c_q.xn);
	assign last_y = (y_q == c_q.yn);
	assign z_lt   = (div_z < $signed(rdd_q));
	assign hit    = (state_q == B_DIV) && div_done && z_lt;
	assign adv    = ((state_q == B_PIX) && !in_tri) || ((state_q == B_DIV) && div_done);
	assign div_start = (state_q == B_PIX) && in_tri;
	assign cmd_pop   = (state_q == B_IDLE) && !cmd_empty;
	assign res_load  = (state_q == B_DONE) && (!res_v_q || pop);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rw_next[i] = rw_q[i] + c_q.dwy[i];
		end
	end
	assign rn_next = rn_q + c_q.ny;
	assign ri_next = ri_q + IDX_W'(SCREEN_W);

	assign we_d = (state_q == B_CLR) || hit;
	assign we_c = (state_q == B_CLR) || (hit && !depth_only);
	assign wa   = (state_q == B_CLR) ? clr_q : ci_q[ADDR_W-1:0];
	assign wd   = (state_q == B_CLR) ? clear_depth : div_z;
	assign wc   = (state_q == B_CLR) ? clear_color : c_q.color;
	assign ra   = (state_q == B_RD) ? c_q.addr : ci_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (we_d) begin
			dmem[wa] <= wd;
		end
		if (we_c) begin
			cmem[wa] <= wc;
		end
		rdd_q <= dmem[ra];
		rdc_q <= cmem[ra];
	end

	assign empty          = !res_v_q;
	assign pixels_written = res_cnt_q;
	assign read_color     = res_color_q;
	assign read_depth     = $signed(res_depth_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			res_v_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_v_q <= 1'b1;
			end else if (pop && res_v_q) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!cmd_empty) begin
						c_q   <= cmd;
						x_q   <= cmd.x0;
						y_q   <= cmd.y0;
						cw_q  <= cmd.w;
						rw_q  <= cmd.w;
						cn_q  <= cmd.n0;
						rn_q  <= cmd.n0;
						ci_q  <= cmd.idx0;
						ri_q  <= cmd.idx0;
						cnt_q <= '0;
						clr_q <= '0;
						pc_q  <= '0;
						pd_q  <= '0;
						case (cmd.kind)
							K_DRAW:  state_q <= B_PIX;
							K_CLEAR: state_q <= B_CLR;
							K_READ:  state_q <= B_RD;
							default: state_q <= B_DONE;
						endcase
					end
				end
				B_PIX, B_DIV: begin
					if (hit) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (adv) begin
						if (last_x) begin
							if (last_y) begin
								state_q <= B_DONE;
							end else begin
								// step to the start of the next row
								state_q <= B_PIX;
								y_q     <= y_q + 1'b1;
								x_q     <= c_q.x0;
								rw_q    <= rw_next;
								cw_q    <= rw_next;
								rn_q    <= rn_next;
								cn_q    <= rn_next;
								ri_q    <= ri_next;
								ci_q    <= ri_next;
							end
						end else begin
							state_q <= B_PIX;
							x_q     <= x_q + 1'b1;
							for (int i = 0; i < 3; i++) begin
								cw_q[i] <= cw_q[i] + c_q.dwx[i];
							end
							cn_q <= cn_q + c_q.nx;
							ci_q <= ci_q + 1'b1;
						end
					end else if (state_q == B_PIX) begin
						state_q <= B_DIV;
					end
				end
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
						state_q <= B_DONE;
					end
				end
				B_RD: begin
					state_q <= B_RDW;
				end
				B_RDW: begin
					pc_q    <= rdc_q;
					pd_q    <= rdd_q;
					state_q <= B_DONE;
				end
				B_DONE: begin
					// hold until the result register is free
					if (res_load) begin
						res_cnt_q   <= cnt_q;
						res_color_q <= pc_q;
						res_depth_q <= pd_q;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_res_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_v_q) |-> $past(state_q) == B_DONE)
		else $error("result appeared without a finished command");
	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == B_DIV)
		else $error("divider finished outside the pixel wait");
	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE && !cmd_empty) |=> state_q != B_IDLE)
		else $error("command transfer did not start work");
	a_read_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_RDW |-> $past(state_q) == B_RD)
		else $error("read capture without read issue");
`endif

endmodule

`default_nettype wire

// ----- tb/triangle_raster_zbuffer_checker.sv -----
// Checker for the triangle rasterizer: predicts every result and compares it on transfer.
`timescale 1ns / 1ps

module triangle_raster_zbuffer_checker import trz_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic               full,
	input  wire logic [1:0]         opcode,
	input  wire logic signed [15:0] ax,
	input  wire logic signed [15:0] ay,
	input  wire logic signed [23:0] az,
	input  wire logic signed [15:0] bx,
	input  wire logic signed [15:0] by_coord,
	input  wire logic signed [23:0] bz,
	input  wire logic signed [15:0] cx,
	input  wire logic signed [15:0] cy,
	input  wire logic signed [23:0] cz,
	input  wire logic [8:0]         light_level,
	input  wire logic [17:0]        read_address,
	input  wire logic               empty,
	input  wire logic               pop,
	input  wire logic [18:0]        pixels_written,
	input  wire logic [31:0]        read_color,
	input  wire logic signed [23:0] read_depth,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	output int                      fails,
	output int                      pending
);

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [COLOR_W-1:0] color;
		logic [ZW-1:0]      depth;
	} pixel_result_t;

	pixel_result_t result_q[$];

	logic [ZW-1:0]      depth_mem [STORE_DEPTH];
	logic [COLOR_W-1:0] color_mem [STORE_DEPTH];
	logic               depth_only_r;
	logic [COLOR_W-1:0] clear_color_r;
	logic [ZW-1:0]      clear_depth_r;

	initial begin
		fails = 0;
		pending = 0;
	end

	function automatic longint edge_fn(longint x0, longint y0, longint x1, longint y1,
			longint px, longint py);
		return (px - x0) * (y1 - y0) - (py - y0) * (x1 - x0);
	endfunction

	function automatic longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	// Pixel range covered on one axis, clipped to the screen.
	function automatic bit span(longint lo, longint hi, longint lim,
			output longint first, output longint last);
		first = 0;
		last = -1;
		if (hi < 0)
			return 0;
		first = (lo < 0) ? 0 : lo / 16;
		last = hi / 16;
		if (last > lim - 1)
			last = lim - 1;
		return first <= last;
	endfunction

	function automatic longint lo3(longint a, longint b, longint c);
		longint m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic longint hi3(longint a, longint b, longint c);
		longint m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	task automatic rasterize(input longint x1, input longint y1, input longint z1,
			input longint x2, input longint y2, input longint z2,
			input longint x3, input longint y3, input longint z3,
			input logic [8:0] lvl, output logic [CNT_W-1:0] cnt);
		longint area, den, xf, xl, yf, yl, x, y, w1, w2, w3, num, z, idx;
		int unsigned lv, grey;
		logic [COLOR_W-1:0] col;
		cnt = '0;
		lv = (lvl > 9'd256) ? 256 : lvl;
		grey = (200 * lv) >> 8;
		col = {grey[7:0], grey[7:0], grey[7:0], 8'h00};
		area = edge_fn(x1, y1, x2, y2, x3, y3);
		if (area >= 0)
			return;
		den = -area;
		if (!span(lo3(x1, x2, x3), hi3(x1, x2, x3), SCREEN_W_DEF, xf, xl))
			return;
		if (!span(lo3(y1, y2, y3), hi3(y1, y2, y3), SCREEN_H_DEF, yf, yl))
			return;
		for (y = yf; y <= yl; y++) begin
			for (x = xf; x <= xl; x++) begin
				w1 = edge_fn(x2, y2, x3, y3, x * 16, y * 16);
				w2 = edge_fn(x3, y3, x1, y1, x * 16, y * 16);
				w3 = edge_fn(x1, y1, x2, y2, x * 16, y * 16);
				if (!(w1 < 0 && w2 < 0 && w3 < 0))
					continue;
				idx = y * SCREEN_W_DEF + x;
				if (idx >= STORE_DEPTH)
					continue;
				num = -(z1 * w1 + z2 * w2 + z3 * w3);
				// round to nearest, ties up
				z = floor_div(2 * num + den, 2 * den);
				if (z < longint'($signed(depth_mem[idx]))) begin
					depth_mem[idx] = z[ZW-1:0];
					if (!depth_only_r)
						color_mem[idx] = col;
					cnt++;
				end
			end
		end
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t r, e;
		if (!arst_n) begin
			result_q.delete();
			depth_only_r <= 1'b0;
			clear_color_r <= 32'h2121_2100;
			clear_depth_r <= 24'h7F_FFFF;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEPTH_ONLY:  depth_only_r <= cfg_data[0];
					CFG_CLEAR_COLOR: clear_color_r <= cfg_data;
					CFG_CLEAR_DEPTH: clear_depth_r <= cfg_data[ZW-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (result_q.size() == 0) begin
					report("unexpected result", pixels_written, 0);
				end else begin
					e = result_q.pop_front();
					if (pixels_written !== e.count)
						report("pixels_written", pixels_written, e.count);
					if (read_color !== e.color)
						report("read_color", read_color, e.color);
					if (read_depth !== e.depth)
						report("read_depth", read_depth, e.depth);
				end
			end
			if (push && !full) begin
				r = '0;
				case (opcode)
					OP_DRAW: rasterize(ax, ay, az, bx, by_coord, bz, cx, cy, cz,
						light_level, r.count);
					OP_CLEAR: begin
						for (int i = 0; i < STORE_DEPTH; i++) begin
							depth_mem[i] = clear_depth_r;
							color_mem[i] = clear_color_r;
						end
					end
					OP_READ: begin
						r.color = color_mem[read_address];
						r.depth = depth_mem[read_address];
					end
					default: ;
				endcase
				result_q.push_back(r);
			end
			pending <= result_q.size();
		end
	end

endmodule

// ----- tb/triangle_raster_zbuffer_test.sv -----
// Testbench top: stimulus, handshake pacing, watchdog and verdict for the rasterizer.
`timescale 1ns / 1ps

module triangle_raster_zbuffer_test;
	import trz_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG = 1200000;
	localparam int SETTLE = 40;

	typedef struct {
		logic [1:0]         op;
		logic signed [15:0] xa, ya, xb, yb, xc, yc;
		logic signed [23:0] za, zb, zc;
		logic [8:0]         light;
		logic [17:0]        addr;
	} raster_cmd_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push, full, empty, pop;
	logic [1:0]         opcode;
	logic signed [15:0] ax, ay, bx, by_coord, cx, cy;
	logic signed [23:0] az, bz, cz;
	logic [8:0]         light_level;
	logic [17:0]        read_address;
	logic [18:0]        pixels_written;
	logic [31:0]        read_color;
	logic signed [23:0] read_depth;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	int                 fails, pending;
	int                 idle_pct, stall_pct;
	int                 quiet_cycles;
	int                 last_px, last_py;

	triangle_raster_zbuffer dut (.*);
	triangle_raster_zbuffer_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		pop <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic raster_cmd_t blank_cmd(logic [1:0] op);
		raster_cmd_t c;
		c.op = op;
		{c.xa, c.ya, c.xb, c.yb} = {$urandom(), $urandom()};
		{c.xc, c.yc} = $urandom();
		c.za = 24'($urandom());
		c.zb = 24'($urandom());
		c.zc = 24'($urandom());
		c.light = 9'($urandom());
		c.addr = 18'($urandom());
		return c;
	endfunction

	function automatic raster_cmd_t tri_cmd(int xa, int ya, int za, int xb, int yb, int zb,
			int xc, int yc, int zc, int lvl);
		raster_cmd_t c;
		c = blank_cmd(OP_DRAW);
		c.xa = 16'(xa); c.ya = 16'(ya); c.za = 24'(za);
		c.xb = 16'(xb); c.yb = 16'(yb); c.zb = 24'(zb);
		c.xc = 16'(xc); c.yc = 16'(yc); c.zc = 24'(zc);
		c.light = 9'(lvl);
		return c;
	endfunction

	function automatic raster_cmd_t read_cmd(int addr);
		raster_cmd_t c;
		c = blank_cmd(OP_READ);
		c.addr = 18'(addr);
		return c;
	endfunction

	function automatic int jitter();
		return int'($urandom_range(128)) - 64;
	endfunction

	// Mostly small triangles near a random spot, some off-screen noise, reads and dead opcodes.
	function automatic raster_cmd_t random_cmd();
		raster_cmd_t c;
		int r, bxp, byp;
		r = $urandom_range(99);
		if (r < 62) begin
			bxp = $urandom_range(527) - 8;
			byp = $urandom_range(527) - 8;
			last_px = bxp;
			last_py = byp;
			c = tri_cmd(bxp * 16 + jitter(), byp * 16 + jitter(), $urandom(),
				bxp * 16 + jitter(), byp * 16 + jitter(), $urandom(),
				bxp * 16 + jitter(), byp * 16 + jitter(), $urandom(),
				($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(256));
		end else if (r < 67) begin
			c = blank_cmd(OP_DRAW);
			if ($urandom_range(1)) begin
				c.xa = 16'($urandom_range(32767, 8192));
				c.xb = 16'($urandom_range(32767, 8192));
				c.xc = 16'($urandom_range(32767, 8192));
			end else begin
				c.xa = 16'(-$urandom_range(32768, 16));
				c.xb = 16'(-$urandom_range(32768, 16));
				c.xc = 16'(-$urandom_range(32768, 16));
			end
		end else if (r < 95) begin
			if ($urandom_range(1))
				c = read_cmd($urandom_range(262143));
			else
				c = read_cmd((((last_py + $urandom_range(8) - 4) & 511) << 9)
					| ((last_px + $urandom_range(8) - 4) & 511));
		end else begin
			c = blank_cmd(OP_UNUSED);
		end
		return c;
	endfunction

	// Leaves push high after the transfer so back-to-back items need no toggle.
	task automatic send(raster_cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		opcode <= c.op;
		ax <= c.xa; ay <= c.ya; az <= c.za;
		bx <= c.xb; by_coord <= c.yb; bz <= c.zb;
		cx <= c.xc; cy <= c.yc; cz <= c.zc;
		light_level <= c.light;
		read_address <= c.addr;
		push <= 1'b1;
		do @(posedge clk); while (full);
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_run(int n);
		for (int i = 0; i < n; i++)
			send(random_cmd());
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DEPTH_ONLY;
		cfg_data = '0;
		opcode = OP_READ;
		{ax, ay, bx, by_coord, cx, cy} = '0;
		{az, bz, cz} = '0;
		light_level = '0;
		read_address = '0;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		last_px = 0;
		last_py = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stores are undefined until the first clear
		send(blank_cmd(OP_CLEAR));
		send(read_cmd(0));
		send(read_cmd(262143));
		send(tri_cmd(32, 32, 1000, 160, 32, 2000, 32, 160, 3000, 256));
		send(tri_cmd(32, 32, 1000, 32, 160, 2000, 160, 32, 3000, 256));
		send(tri_cmd(32, 32, 0, 64, 64, 0, 96, 96, 0, 256));
		send(read_cmd(3 * 512 + 3));
		// same depth again must not win, a nearer one must
		send(tri_cmd(32, 32, 1000, 160, 32, 2000, 32, 160, 3000, 0));
		send(tri_cmd(32, 32, -5000, 160, 32, -5000, 32, 160, -5000, 511));
		send(read_cmd(3 * 512 + 3));
		send(tri_cmd(320, 320, -8388608, 400, 320, -8388608, 320, 400, -8388608, 255));
		send(tri_cmd(480, 320, 8388607, 560, 320, 8388607, 480, 400, 8388607, 128));
		send(tri_cmd(32767, 32767, 0, 32767, 32767, 0, 32767, 32767, 0, 1));
		send(tri_cmd(-32768, -32768, 0, -32768, -32768, 0, -32768, -32768, 0, 1));
		send(tri_cmd(-32768, 0, 7, 32767, 16, 9, -32768, 32, 11, 200));
		send(tri_cmd(-32768, 0, 7, -32768, 32, 9, 32767, 16, 11, 200));
		send(tri_cmd(8080, 8080, 100, 8240, 8080, -100, 8080, 8240, 50, 257));
		send(tri_cmd(-40, -40, 100, 60, -40, 200, -40, 60, 300, 100));
		send(read_cmd(511 * 512 + 511));
		send(read_cmd(1 * 512 + 18));
		send(blank_cmd(OP_UNUSED));
		send(read_cmd(130000));
		random_run(150);
		settle();

		write_reg(CFG_DEPTH_ONLY, 32'd1);
		idle_pct = 73;
		random_run(160);
		settle();

		write_reg(CFG_DEPTH_ONLY, 32'd0);
		write_reg(CFG_CLEAR_COLOR, 32'hFFFF_FFFF);
		write_reg(CFG_CLEAR_DEPTH, 32'h0080_0000);
		idle_pct = 0;
		stall_pct = 73;
		send(blank_cmd(OP_CLEAR));
		random_run(150);
		settle();

		write_reg(CFG_CLEAR_COLOR, 32'h0000_0000);
		write_reg(CFG_CLEAR_DEPTH, 32'h007F_FFFF);
		idle_pct = 12;
		stall_pct = 12;
		send(blank_cmd(OP_CLEAR));
		random_run(160);
		settle();

		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
